// ===== design/qrs_pkg.sv =====
package qrs_pkg;

	typedef enum logic [1:0] {
		CLASS_DISTINCT = 2'd0,
		CLASS_EQUAL    = 2'd1,
		CLASS_COMPLEX  = 2'd2,
		CLASS_DEGEN    = 2'd3
	} root_class_t;

	localparam int OUT_BITS = 21;

endpackage

// ===== design/qrs_coef_if.sv =====
interface qrs_coef_if #(
	parameter int COEF_BITS = 12
);
	logic                        valid;
	logic                        ready;
	logic signed [COEF_BITS-1:0] coef_a;
	logic signed [COEF_BITS-1:0] coef_b;
	logic signed [COEF_BITS-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// ===== design/qrs_root_if.sv =====
interface qrs_root_if;
	import qrs_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 root_class;
	logic signed [OUT_BITS-1:0] root_plus;
	logic signed [OUT_BITS-1:0] root_minus;

	modport source (output valid, root_class, root_plus, root_minus, input ready);
	modport sink   (input valid, root_class, root_plus, root_minus, output ready);
endinterface

// ===== design/qrs_sqrt_cell.sv =====
// One digit of a restoring square root; carries the sideband along.
module qrs_sqrt_cell import qrs_pkg::*; #(
	parameter int RW = 32,
	parameter int DW = 40,
	parameter int SW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [RW-1:0] rem_i,
	input  logic [RW-1:0] root_i,
	input  logic [DW-1:0] d_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [RW-1:0] rem_o,
	output logic [RW-1:0] root_o,
	output logic [DW-1:0] d_o,
	output logic [SW-1:0] side_o
);
	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          ge;

	assign rem_sh = {rem_i[RW-3:0], d_i[DW-1 -: 2]};
	assign trial  = {root_i[RW-3:0], 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? rem_sh - trial : rem_sh;
			root_o <= {root_i[RW-2:0], ge};
			d_o    <= {d_i[DW-3:0], 2'b00};
			side_o <= side_i;
		end
	end
endmodule

// ===== design/qrs_div_cell.sv =====
// One quotient bit for each of two restoring divides on magnitudes, sharing a divisor.
module qrs_div_cell import qrs_pkg::*; #(
	parameter int NW = 40,
	parameter int VW = 16,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [NW-1:0] rp_i,
	input  logic [NW-1:0] qp_i,
	input  logic [NW-1:0] rm_i,
	input  logic [NW-1:0] qm_i,
	input  logic [VW-1:0] dv_i,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [NW-1:0] rp_o,
	output logic [NW-1:0] qp_o,
	output logic [NW-1:0] rm_o,
	output logic [NW-1:0] qm_o,
	output logic [VW-1:0] dv_o,
	output logic [SW-1:0] side_o
);
	logic [NW:0] tp;
	logic [NW:0] tm;
	logic        gp;
	logic        gm;

	assign tp = {rp_i, qp_i[NW-1]};
	assign tm = {rm_i, qm_i[NW-1]};
	assign gp = tp >= {{(NW+1-VW){1'b0}}, dv_i};
	assign gm = tm >= {{(NW+1-VW){1'b0}}, dv_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_o   <= gp ? NW'(tp - {{(NW+1-VW){1'b0}}, dv_i}) : tp[NW-1:0];
			rm_o   <= gm ? NW'(tm - {{(NW+1-VW){1'b0}}, dv_i}) : tm[NW-1:0];
			qp_o   <= {qp_i[NW-2:0], gp};
			qm_o   <= {qm_i[NW-2:0], gm};
			dv_o   <= dv_i;
			side_o <= side_i;
		end
	end
endmodule

// ===== design/quadratic_root_solver.sv =====
// Quadratic root solver. One coefficient triple transfers per cycle unless the
// chain stalls. The result passes the products register, the discriminant
// register, one square-root cell per digit (COEF_BITS+1+FRAC_BITS cells), the
// numerator register, then one divider cell per quotient bit
// (2*COEF_BITS+2*FRAC_BITS+3 cells), and the output register fed by sign and
// saturation. The whole chain stalls while the output holds an untaken result;
// a skid-free stall of all cells keeps items in order. No state between items,
// nothing to configure.
module quadratic_root_solver import qrs_pkg::*; #(
	parameter int COEF_BITS = 12,
	parameter int FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	qrs_coef_if.sink     coef_in,
	qrs_root_if.source   root_out
);
	localparam int DW  = 2*COEF_BITS + 2;
	localparam int NP  = DW/2;
	localparam int NSQ = NP + FRAC_BITS;
	localparam int RW  = NSQ + 3;
	localparam int SQW = NSQ;
	localparam int NW  = COEF_BITS + FRAC_BITS + SQW + 2;
	localparam int VW  = COEF_BITS + 1;
	localparam int SIDE = 2 + 1 + 1 + COEF_BITS + VW;

	logic en;
	logic out_v_q;
	assign en = !out_v_q || root_out.ready;
	assign coef_in.ready = en;

	// stage 1: products
	logic                          v_s1;
	logic signed [2*COEF_BITS-1:0] bb_s1;
	logic signed [2*COEF_BITS+1:0] ac4_s1;
	logic signed [COEF_BITS-1:0]   a_s1, b_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= coef_in.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1  <= coef_in.coef_b * coef_in.coef_b;
			ac4_s1 <= (2*COEF_BITS+2)'(coef_in.coef_a * coef_in.coef_c) <<< 2;
			a_s1   <= coef_in.coef_a;
			b_s1   <= coef_in.coef_b;
		end
	end

	// stage 2: discriminant and class
	logic                 v_s2;
	logic [DW-1:0]        d_s2;
	logic [1:0]           cls_s2;
	logic signed [COEF_BITS-1:0] b_s2;
	logic [VW-1:0]        dv_s2;
	logic                 neg_s2;
	logic signed [DW:0]   dsum;
	logic signed [VW-1:0] a2;
	assign dsum = (DW+1)'(bb_s1) - (DW+1)'(ac4_s1);
	assign a2   = VW'(a_s1) <<< 1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (a_s1 == '0) cls_s2 <= CLASS_DEGEN;
			else if (dsum < 0)       cls_s2 <= CLASS_COMPLEX;
			else if (dsum == 0)      cls_s2 <= CLASS_EQUAL;
			else                     cls_s2 <= CLASS_DISTINCT;
			d_s2   <= (dsum < 0) ? '0 : dsum[DW-1:0];
			b_s2   <= b_s1;
			neg_s2 <= a_s1[COEF_BITS-1];
			dv_s2  <= a_s1[COEF_BITS-1] ? VW'(-a2) : a2;
		end
	end

	// square root chain
	logic [NSQ:0]         sv;
	logic [RW-1:0]        srem [NSQ+1];
	logic [RW-1:0]        sroot[NSQ+1];
	logic [DW+2*FRAC_BITS-1:0] sd[NSQ+1];
	logic [SIDE-1:0]      sside[NSQ+1];
	assign sv[0]    = v_s2;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sd[0]    = {d_s2, {(2*FRAC_BITS){1'b0}}};
	assign sside[0] = {cls_s2, 1'b0, neg_s2, b_s2, dv_s2};
	for (genvar i = 0; i < NSQ; i++) begin : g_sq
		qrs_sqrt_cell #(.RW(RW), .DW(DW+2*FRAC_BITS), .SW(SIDE)) u_cell (
			.clk, .arst_n, .en,
			.vld_i(sv[i]), .rem_i(srem[i]), .root_i(sroot[i]), .d_i(sd[i]),
			.side_i(sside[i]),
			.vld_o(sv[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]),
			.d_o(sd[i+1]), .side_o(sside[i+1])
		);
	end

	// numerators
	logic [1:0]           cls_q;
	logic                 neg_q;
	logic signed [COEF_BITS-1:0] b_q;
	logic [VW-1:0]        dv_q;
	assign {cls_q, neg_q, b_q, dv_q} = {sside[NSQ][SIDE-1 -: 2], sside[NSQ][SIDE-4:0]};
	logic signed [NW:0] nb, np, nm;
	assign nb = -((NW+1)'(b_q) <<< FRAC_BITS);
	assign np = nb + (NW+1)'({1'b0, sroot[NSQ][SQW-1:0]});
	assign nm = nb - (NW+1)'({1'b0, sroot[NSQ][SQW-1:0]});

	logic            v_s3;
	logic [NW-1:0]   mp_s3, mm_s3;
	logic [VW-1:0]   dv_s3;
	logic [4:0]      sg_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= sv[NSQ];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mp_s3 <= np[NW] ? NW'(-np) : np[NW-1:0];
			mm_s3 <= nm[NW] ? NW'(-nm) : nm[NW-1:0];
			dv_s3 <= dv_q;
			sg_s3 <= {cls_q, neg_q, np[NW], nm[NW]};
		end
	end

	// divider chain
	logic [NW:0]     dvv;
	logic [NW-1:0]   rp[NW+1], qp[NW+1], rm[NW+1], qm[NW+1];
	logic [VW-1:0]   dvd[NW+1];
	logic [4:0]      dside[NW+1];
	assign dvv[0] = v_s3;
	assign rp[0] = '0;
	assign rm[0] = '0;
	assign qp[0] = mp_s3;
	assign qm[0] = mm_s3;
	assign dvd[0] = dv_s3;
	assign dside[0] = sg_s3;
	for (genvar j = 0; j < NW; j++) begin : g_dv
		qrs_div_cell #(.NW(NW), .VW(VW), .SW(5)) u_cell (
			.clk, .arst_n, .en,
			.vld_i(dvv[j]), .rp_i(rp[j]), .qp_i(qp[j]), .rm_i(rm[j]), .qm_i(qm[j]),
			.dv_i(dvd[j]), .side_i(dside[j]),
			.vld_o(dvv[j+1]), .rp_o(rp[j+1]), .qp_o(qp[j+1]), .rm_o(rm[j+1]),
			.qm_o(qm[j+1]), .dv_o(dvd[j+1]), .side_o(dside[j+1])
		);
	end

	// sign, saturate, output
	logic [1:0]  fcls;
	logic        fneg, fsp, fsm;
	assign {fcls, fneg, fsp, fsm} = dside[NW];
	logic signed [NW:0] vp, vm;
	assign vp = (fneg ^ fsp) ? -(NW+1)'(qp[NW]) : (NW+1)'(qp[NW]);
	assign vm = (fneg ^ fsm) ? -(NW+1)'(qm[NW]) : (NW+1)'(qm[NW]);

	localparam logic signed [NW:0] HI = (NW+1)'((1 << (OUT_BITS-1)) - 1);
	localparam logic signed [NW:0] LO = -HI - 1;

	function automatic logic [OUT_BITS-1:0] sat(input logic signed [NW:0] v);
		if (v > HI) return HI[OUT_BITS-1:0];
		if (v < LO) return LO[OUT_BITS-1:0];
		return v[OUT_BITS-1:0];
	endfunction

	logic              real_r;
	assign real_r = fcls == CLASS_DISTINCT || fcls == CLASS_EQUAL;

	logic [1:0]          cls_o_q;
	logic [OUT_BITS-1:0] rp_o_q, rm_o_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dvv[NW];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cls_o_q <= fcls;
			rp_o_q  <= real_r ? sat(vp) : '0;
			rm_o_q  <= real_r ? sat(vm) : '0;
		end
	end

	assign root_out.valid      = out_v_q;
	assign root_out.root_class = cls_o_q;
	assign root_out.root_plus  = rp_o_q;
	assign root_out.root_minus = rm_o_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !root_out.ready |=> out_v_q && $stable(rp_o_q) && $stable(cls_o_q))
		else $error("result changed under stall");
	a_cplx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (cls_o_q == CLASS_COMPLEX || cls_o_q == CLASS_DEGEN)
		|-> rp_o_q == '0 && rm_o_q == '0)
		else $error("nonzero root without real class");
	a_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && cls_o_q == CLASS_EQUAL |-> rp_o_q == rm_o_q)
		else $error("equal roots differ");
endmodule

// ===== dv/qrs_checker.sv =====
`timescale 1ns / 1ps
module qrs_checker import qrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	qrs_coef_if   coef_mon,
	qrs_root_if   root_mon,
	output int    fail_count,
	output int    pending
);
	typedef struct packed {
		root_class_t                 cls;
		logic signed [OUT_BITS-1:0] plus;
		logic signed [OUT_BITS-1:0] minus;
	} roots_t;

	roots_t expected_roots[$];

	function automatic longint unsigned sqrt_frac(longint unsigned d);
		longint unsigned rem, root, pair, trial;
		rem = 0;
		root = 0;
		for (int i = 0; i < 28; i++) begin
			pair = (i < 20) ? ((d >> (2 * (19 - i))) & 3) : 0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic signed [OUT_BITS-1:0] clamp_root(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[OUT_BITS-1:0];
	endfunction

	function automatic roots_t solve_roots(logic signed [11:0] ca, logic signed [11:0] cb,
			logic signed [11:0] cc);
		roots_t r;
		longint a, b, c, disc, nb, den, s;
		a = longint'(ca);
		b = longint'(cb);
		c = longint'(cc);
		r.plus = '0;
		r.minus = '0;
		if (a == 0) begin
			r.cls = CLASS_DEGEN;
			return r;
		end
		disc = b * b - 4 * a * c;
		if (disc < 0) begin
			r.cls = CLASS_COMPLEX;
			return r;
		end
		r.cls = (disc == 0) ? CLASS_EQUAL : CLASS_DISTINCT;
		s = longint'(sqrt_frac(disc));
		nb = -b * 256;
		den = 2 * a;
		r.plus = clamp_root((nb + s) / den);
		r.minus = clamp_root((nb - s) / den);
		return r;
	endfunction

	assign pending = expected_roots.size();

	always @(posedge clk or negedge arst_n) begin
		roots_t exp_r;
		int     errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (coef_mon.valid && coef_mon.ready)
				expected_roots.push_back(solve_roots(coef_mon.coef_a, coef_mon.coef_b,
					coef_mon.coef_c));
			if (root_mon.valid && root_mon.ready) begin
				if (expected_roots.size() == 0) begin
					$error("unexpected result transfer");
					errs++;
				end else begin
					exp_r = expected_roots.pop_front();
					if (root_mon.root_class !== exp_r.cls) begin
						$error("root_class exp %0d got %0d", exp_r.cls, root_mon.root_class);
						errs++;
					end
					if (root_mon.root_plus !== exp_r.plus) begin
						$error("root_plus exp %0d got %0d", exp_r.plus, root_mon.root_plus);
						errs++;
					end
					if (root_mon.root_minus !== exp_r.minus) begin
						$error("root_minus exp %0d got %0d", exp_r.minus, root_mon.root_minus);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   send_idle_pct = 35;
	int   recv_idle_pct = 54;

	qrs_coef_if #(.COEF_BITS(12)) coef_ch ();
	qrs_root_if root_ch ();

	quadratic_root_solver DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef_in  (coef_ch.sink),
		.root_out (root_ch.source)
	);

	qrs_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_mon   (coef_ch),
		.root_mon   (root_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	initial begin
		coef_ch.valid = 1'b0;
		coef_ch.coef_a = '0;
		coef_ch.coef_b = '0;
		coef_ch.coef_c = '0;
		root_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			root_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hold valid until the transfer, with random gaps between items
	task automatic send_coefs(logic [11:0] a, logic [11:0] b, logic [11:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			coef_ch.valid <= 1'b0;
			@(posedge clk);
		end
		coef_ch.valid <= 1'b1;
		coef_ch.coef_a <= a;
		coef_ch.coef_b <= b;
		coef_ch.coef_c <= c;
		@(posedge clk);
		while (!coef_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [11:0] a, b, c;
		int r, k;
		a = 12'($urandom);
		b = 12'($urandom);
		c = 12'($urandom);
		r = int'($urandom_range(9));
		if (r == 0) begin
			a = '0;
		end else if (r < 3) begin
			// real roots: c = -a*k with small k keeps the discriminant non-negative
			a = 12'($urandom_range(1, 40));
			k = int'($urandom_range(0, 1));
			if (k != 0) a = -a;
			b = 12'($urandom_range(0, 4095));
			c = 12'(-(int'($signed(a)) * int'($urandom_range(0, 40))));
		end else if (r == 3) begin
			// equal roots: b = 2m, a = 1, c = m*m
			k = int'($urandom_range(0, 45));
			a = 12'd1;
			b = ($urandom_range(1) != 0) ? 12'(2 * k) : 12'(-2 * k);
			c = 12'(k * k);
		end else if (r == 4) begin
			a = 12'(int'($urandom_range(0, 7)) - 4);
		end
		send_coefs(a, b, c);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_coefs(12'h800, 12'h800, 12'h800);
		send_coefs(12'h7ff, 12'h7ff, 12'h7ff);
		send_coefs(12'h7ff, 12'h800, 12'h800);
		send_coefs(12'h800, 12'h7ff, 12'h7ff);
		send_coefs(12'h001, 12'h800, 12'h7ff);
		send_coefs(12'h001, 12'h7ff, 12'h800);
		send_coefs(12'hfff, 12'h800, 12'h800);
		send_coefs(12'h000, 12'h123, 12'h456);
		send_coefs(12'h000, 12'h000, 12'h000);
		send_coefs(12'h001, 12'h002, 12'h001);
		send_coefs(12'h001, 12'h000, 12'h000);
		send_coefs(12'h001, 12'h000, 12'h001);
		send_coefs(12'h001, 12'hffd, 12'h002);
		send_coefs(12'hffe, 12'h004, 12'h006);
		send_coefs(12'h7ff, 12'h000, 12'h800);
		send_coefs(12'h001, 12'h000, 12'h800);
		send_coefs(12'h001, 12'h003, 12'h000);
		send_coefs(12'h555, 12'haaa, 12'h555);
		send_coefs(12'haaa, 12'h555, 12'haaa);
		for (int i = 0; i < 640; i++) send_random();
		send_idle_pct = 54;
		recv_idle_pct = 35;
		for (int i = 0; i < 640; i++) send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 640; i++) send_random();
		coef_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** quadratic_root_solver: PASSED **");
		else
			$display("** quadratic_root_solver: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** quadratic_root_solver: FAILED **");
		$finish;
	end
endmodule
